FILE: src/tlts_pkg.sv
// Shared widths, codes and reset values for the toolpath length and time statistics block.
`timescale 1ns / 1ps
`default_nettype none
package tlts_pkg;

    // Field widths.
    localparam int COORD_W = 32;              // signed Q16.16 coordinate
    localparam int RATE_W  = 32;              // unsigned Q16.16 rate
    localparam int DIFF_W  = COORD_W;         // magnitude of a coordinate difference
    localparam int SQSUM_W = 2 * DIFF_W + 2;  // sum of three squares
    localparam int ROOT_W  = SQSUM_W / 2;     // segment length, Q17.16
    localparam int FRAC_W  = 16;
    localparam int NUM_W   = ROOT_W + FRAC_W; // dividend of the time estimate
    localparam int QUOT_W  = NUM_W;
    localparam int ACC_W   = 48;              // length and time totals, Q32.16
    localparam int TALLY_W = 32;

    // Packed stream widths.
    localparam int S_DATA_W = 7 * 32;
    localparam int S_USER_W = 3;
    localparam int M_PAY_W  = 3 * ACC_W + TALLY_W + ACC_W + TALLY_W + 1;
    localparam int M_DATA_W = ((M_PAY_W + 7) / 8) * 8;

    localparam logic [RATE_W-1:0] TRAVERSE_RATE_RESET = 32'd327680000;

    // Request codes carried in tuser.
    localparam logic ACT_SEGMENT = 1'b0;
    localparam logic ACT_FINISH  = 1'b1;

    localparam logic [1:0] KIND_RAPID  = 2'd0;
    localparam logic [1:0] KIND_FEED   = 2'd1;
    localparam logic [1:0] KIND_PLUNGE = 2'd2;

endpackage
`default_nettype wire

FILE: src/tlts_sqsum.sv
// Bit-serial sum of the squares of three coordinate differences.
`timescale 1ns / 1ps
`default_nettype none
module tlts_sqsum
    import tlts_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [DIFF_W-1:0]  i_dx,
    input  wire logic [DIFF_W-1:0]  i_dy,
    input  wire logic [DIFF_W-1:0]  i_dz,
    output logic                    o_done,
    output logic [SQSUM_W-1:0]      o_sum
);

    localparam int CW = $clog2(DIFF_W);
    localparam logic [CW-1:0] LAST = CW'(DIFF_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [DIFF_W-1:0] r_mc_x, r_mc_y, r_mc_z;
    logic [DIFF_W-1:0] r_mp_x, r_mp_y, r_mp_z;
    logic [SQSUM_W-1:0] r_acc;
    logic [DIFF_W+1:0] w_pp;

    // Multiplier bits are taken most significant first, so the sum shifts left.
    assign w_pp = {2'b00, (r_mp_x[DIFF_W-1] ? r_mc_x : '0)}
                + {2'b00, (r_mp_y[DIFF_W-1] ? r_mc_y : '0)}
                + {2'b00, (r_mp_z[DIFF_W-1] ? r_mc_z : '0)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mc_x <= i_dx;
            r_mc_y <= i_dy;
            r_mc_z <= i_dz;
            r_mp_x <= i_dx;
            r_mp_y <= i_dy;
            r_mp_z <= i_dz;
            r_acc  <= '0;
        end else if (r_busy) begin
            r_acc  <= {r_acc[SQSUM_W-2:0], 1'b0} + SQSUM_W'(w_pp);
            r_mp_x <= {r_mp_x[DIFF_W-2:0], 1'b0};
            r_mp_y <= {r_mp_y[DIFF_W-2:0], 1'b0};
            r_mp_z <= {r_mp_z[DIFF_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_acc;

endmodule
`default_nettype wire

FILE: src/tlts_sqrt.sv
// Restoring square root, one result bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module tlts_sqrt
    import tlts_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [SQSUM_W-1:0] i_rad,
    output logic                    o_done,
    output logic [ROOT_W-1:0]       o_root
);

    localparam int CW    = $clog2(ROOT_W);
    localparam int REM_W = ROOT_W + 2;
    localparam int SH_W  = REM_W + 2;
    localparam logic [CW-1:0] LAST = CW'(ROOT_W - 1);

    logic               r_busy;
    logic               r_done;
    logic [CW-1:0]      r_cnt;
    logic [SQSUM_W-1:0] r_rad;
    logic [REM_W-1:0]   r_rem;
    logic [ROOT_W-1:0]  r_root;
    logic [SH_W-1:0]    w_rem_sh;
    logic [SH_W-1:0]    w_trial;
    logic [SH_W-1:0]    w_diff;
    logic               w_take;

    assign w_rem_sh = {r_rem, r_rad[SQSUM_W-1 -: 2]};
    assign w_trial  = {2'b00, r_root, 2'b01};
    assign w_take   = (w_rem_sh >= w_trial);
    assign w_diff   = w_rem_sh - w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[SQSUM_W-3:0], 2'b00};
            r_rem  <= w_take ? w_diff[REM_W-1:0] : w_rem_sh[REM_W-1:0];
            r_root <= {r_root[ROOT_W-2:0], w_take};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule
`default_nettype wire

FILE: src/tlts_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module tlts_div
    import tlts_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [RATE_W-1:0] i_den,
    output logic                   o_done,
    output logic [QUOT_W-1:0]      o_quot
);

    localparam int CW = $clog2(NUM_W);
    localparam logic [CW-1:0] LAST = CW'(NUM_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [NUM_W-1:0]  r_num;
    logic [RATE_W-1:0] r_rem;
    logic [RATE_W-1:0] r_den;
    logic [RATE_W:0]   w_rem_sh;
    logic [RATE_W:0]   w_sub;
    logic              w_ge;

    assign w_rem_sh = {r_rem, r_num[NUM_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den});
    assign w_sub    = w_rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Dividend bits leave at the top while quotient bits enter at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_sub[RATE_W-1:0] : w_rem_sh[RATE_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule
`default_nettype wire

FILE: src/toolpath_length_time_statistics.sv
// Top level of the toolpath length and time statistics block.
`timescale 1ns / 1ps
`default_nettype none
// Toolpath length and time statistics. Each segment request carries a move kind, start and
// end points in signed Q16.16 and a feed rate; its Euclidean length is added to the total
// for its kind and length / rate is added to the estimated minutes, with rapids using the
// rapid rate register instead. A finish request emits every total on the master side as one
// result and clears the totals. A segment keeps the block busy until it has been
// accumulated, so no new request is taken while one is worked on: the squarer loads on the
// accepting edge and runs, the square-root unit loads when the squarer reports done, the
// divider loads when the root is done, then the sequencer moves on to its accumulate step
// and accumulates. When the rate is zero the divider is skipped. A finish request is held
// off while a segment is in progress or while an earlier result still waits on the master
// side and is not being taken. The rapid rate register may be written at any time the
// block is idle and takes effect for the next segment.
module toolpath_length_time_statistics
    import tlts_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Configuration: rapid traverse rate, unsigned Q16.16 per minute.
    input  wire logic                i_cfg_wr_en,
    input  wire logic [RATE_W-1:0]   i_cfg_wr_data,
    // Slave side.
    input  wire logic                i_s_tvalid,
    output logic                     o_s_tready,
    // tdata from bit 0: start_x, start_y, start_z, end_x, end_y, end_z, move_rate.
    input  wire logic [S_DATA_W-1:0] i_s_tdata,
    // tuser from bit 0: action, move_kind.
    input  wire logic [S_USER_W-1:0] i_s_tuser,
    // Master side.
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    // tdata from bit 0: rapid_total, feed_total, plunge_total, segments_seen, minutes_total,
    // retracts_seen, rate_fault, then zero padding.
    output logic [M_DATA_W-1:0]      o_m_tdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_ROOT,
        S_DIV,
        S_ACC
    } t_state;

    t_state              r_state;
    logic [RATE_W-1:0]   r_traverse_rate;
    logic [1:0]          r_kind;
    logic [RATE_W-1:0]   r_rate;
    logic                r_rise;
    logic [ACC_W-1:0]    r_rapid_sum;
    logic [ACC_W-1:0]    r_feed_sum;
    logic [ACC_W-1:0]    r_plunge_sum;
    logic [ACC_W-1:0]    r_min_sum;
    logic [TALLY_W-1:0]  r_seg_tally;
    logic [TALLY_W-1:0]  r_ret_tally;
    logic                r_fault;
    logic                r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;

    // Request fields.
    logic                       w_action;
    logic [1:0]                 w_move_kind;
    logic signed [COORD_W-1:0]  w_start_x, w_start_y, w_start_z;
    logic signed [COORD_W-1:0]  w_end_x, w_end_y, w_end_z;
    logic [RATE_W-1:0]          w_move_rate;

    logic signed [COORD_W:0]    w_dx_s, w_dy_s, w_dz_s;
    logic [DIFF_W-1:0]          w_dx_a, w_dy_a, w_dz_a;

    logic                       w_s_acc;
    logic                       w_finish_acc;
    logic                       w_seg_acc;

    logic                       w_sq_done;
    logic [SQSUM_W-1:0]         w_sqsum;
    logic                       w_root_done;
    logic [ROOT_W-1:0]          w_root;
    logic                       w_div_start;
    logic                       w_div_done;
    logic [QUOT_W-1:0]          w_quot;

    logic [ACC_W:0]             w_len_sum;
    logic [ACC_W-1:0]           w_len_sat;
    logic [ACC_W+1:0]           w_min_add;
    logic [ACC_W-1:0]           w_min_sat;
    logic [M_PAY_W-1:0]         w_payload;

    assign w_action    = i_s_tuser[0];
    assign w_move_kind = i_s_tuser[2:1];
    assign w_start_x   = i_s_tdata[0*COORD_W +: COORD_W];
    assign w_start_y   = i_s_tdata[1*COORD_W +: COORD_W];
    assign w_start_z   = i_s_tdata[2*COORD_W +: COORD_W];
    assign w_end_x     = i_s_tdata[3*COORD_W +: COORD_W];
    assign w_end_y     = i_s_tdata[4*COORD_W +: COORD_W];
    assign w_end_z     = i_s_tdata[5*COORD_W +: COORD_W];
    assign w_move_rate = i_s_tdata[6*COORD_W +: RATE_W];

    // Requests are taken only when idle; a finish also waits for the last result to be taken.
    // Nothing is taken while the block is held in reset.
    assign o_s_tready   = i_rst_n && (r_state == S_IDLE)
                       && ((w_action != ACT_FINISH) || !r_out_valid || i_m_tready);
    assign w_s_acc      = i_s_tvalid && o_s_tready;
    assign w_finish_acc = w_s_acc && (w_action == ACT_FINISH);
    assign w_seg_acc    = w_s_acc && (w_action == ACT_SEGMENT);

    // Differences are exact in 33 bits; their magnitudes always fit in 32.
    assign w_dx_s = {w_end_x[COORD_W-1], w_end_x} - {w_start_x[COORD_W-1], w_start_x};
    assign w_dy_s = {w_end_y[COORD_W-1], w_end_y} - {w_start_y[COORD_W-1], w_start_y};
    assign w_dz_s = {w_end_z[COORD_W-1], w_end_z} - {w_start_z[COORD_W-1], w_start_z};
    assign w_dx_a = w_dx_s[COORD_W] ? DIFF_W'(-w_dx_s) : DIFF_W'(w_dx_s);
    assign w_dy_a = w_dy_s[COORD_W] ? DIFF_W'(-w_dy_s) : DIFF_W'(w_dy_s);
    assign w_dz_a = w_dz_s[COORD_W] ? DIFF_W'(-w_dz_s) : DIFF_W'(w_dz_s);

    tlts_sqsum u_sqsum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_seg_acc),
        .i_dx    (w_dx_a),
        .i_dy    (w_dy_a),
        .i_dz    (w_dz_a),
        .o_done  (w_sq_done),
        .o_sum   (w_sqsum)
    );

    tlts_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_done),
        .i_rad   (w_sqsum),
        .o_done  (w_root_done),
        .o_root  (w_root)
    );

    // With a zero rate no time is estimated, so the divider is not started.
    assign w_div_start = w_root_done && (r_rate != '0);

    tlts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   ({w_root, {FRAC_W{1'b0}}}),
        .i_den   (r_rate),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Saturating additions. Only one length total moves per segment, so one adder serves
    // all three; the target is picked by the segment's kind.
    always_comb begin
        logic [ACC_W-1:0] v_len_base;
        case (r_kind)
            KIND_RAPID: v_len_base = r_rapid_sum;
            KIND_FEED:  v_len_base = r_feed_sum;
            default:    v_len_base = r_plunge_sum;
        endcase
        w_len_sum = {1'b0, v_len_base} + (ACC_W + 1)'(w_root);
        w_len_sat = w_len_sum[ACC_W] ? {ACC_W{1'b1}} : w_len_sum[ACC_W-1:0];
    end

    assign w_min_add = {2'b00, r_min_sum} + (ACC_W + 2)'(w_quot);
    assign w_min_sat = (w_min_add[ACC_W+1:ACC_W] != 2'b00) ? {ACC_W{1'b1}}
                                                          : w_min_add[ACC_W-1:0];

    assign w_payload = {r_fault, r_ret_tally, r_min_sum, r_seg_tally,
                        r_plunge_sum, r_feed_sum, r_rapid_sum};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_traverse_rate <= TRAVERSE_RATE_RESET;
            r_rapid_sum     <= '0;
            r_feed_sum      <= '0;
            r_plunge_sum    <= '0;
            r_min_sum       <= '0;
            r_seg_tally     <= '0;
            r_ret_tally     <= '0;
            r_fault         <= 1'b0;
            r_out_valid     <= 1'b0;
            r_kind          <= KIND_RAPID;
            r_rate          <= '0;
            r_rise          <= 1'b0;
            r_out_data      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_traverse_rate <= i_cfg_wr_data;
            end

            // A new result may replace one that is taken in the same cycle.
            if (w_finish_acc) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_finish_acc) begin
                        r_out_data   <= M_DATA_W'(w_payload);
                        r_rapid_sum  <= '0;
                        r_feed_sum   <= '0;
                        r_plunge_sum <= '0;
                        r_min_sum    <= '0;
                        r_seg_tally  <= '0;
                        r_ret_tally  <= '0;
                        r_fault      <= 1'b0;
                    end else if (w_seg_acc) begin
                        r_kind  <= w_move_kind;
                        r_rate  <= (w_move_kind == KIND_RAPID) ? r_traverse_rate
                                                               : w_move_rate;
                        r_rise  <= (w_end_z > w_start_z);
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (w_sq_done) begin
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (w_root_done) begin
                        r_state <= w_div_start ? S_DIV : S_ACC;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    case (r_kind)
                        KIND_RAPID: r_rapid_sum <= w_len_sat;
                        KIND_FEED:  r_feed_sum  <= w_len_sat;
                        default:    r_plunge_sum <= w_len_sat;
                    endcase
                    if (r_rate == '0) begin
                        r_fault <= 1'b1;
                    end else begin
                        r_min_sum <= w_min_sat;
                    end
                    if (r_seg_tally != {TALLY_W{1'b1}}) begin
                        r_seg_tally <= r_seg_tally + 1'b1;
                    end
                    if ((r_kind == KIND_RAPID) && r_rise
                        && (r_ret_tally != {TALLY_W{1'b1}})) begin
                        r_ret_tally <= r_ret_tally + 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // The squarer finishes only while the sequencer waits for it.
    a_sq_done_in_sq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_done |-> (r_state == S_SQ))
        else $error("squarer finished outside its phase");

    // The divider finishes only while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside its phase");

    // An accepted finish request always presents a result in the next cycle.
    a_finish_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish_acc |=> o_m_tvalid)
        else $error("finish request produced no result");

    // An accepted finish request leaves the segment tally, minutes total and fault flag cleared.
    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish_acc |=> ((r_seg_tally == '0) && (r_min_sum == '0) && !r_fault))
        else $error("totals not cleared by finish request");

endmodule
`default_nettype wire

FILE: bench/toolpath_stats_checker.sv
// Checker that predicts and compares the totals produced by the toolpath statistics block.
`timescale 1ns / 1ps
`default_nettype none
module toolpath_stats_checker
    import tlts_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [RATE_W-1:0]   i_cfg_wr_data,
    input  wire logic                i_s_tvalid,
    input  wire logic                i_s_tready,
    input  wire logic [S_DATA_W-1:0] i_s_tdata,
    input  wire logic [S_USER_W-1:0] i_s_tuser,
    input  wire logic                i_m_tvalid,
    input  wire logic                i_m_tready,
    input  wire logic [M_DATA_W-1:0] i_m_tdata,
    output int                       o_fails,
    output int                       o_results_due
);

    localparam int                 MAG_W        = DIFF_W + 1;
    localparam int                 LEN_W        = SQSUM_W / 2;
    localparam logic [ACC_W-1:0]   ACC_MAX      = '1;
    localparam logic [TALLY_W-1:0] TALLY_MAX    = '1;
    localparam int                 REPORT_LIMIT = 10;

    typedef struct packed {
        logic [ACC_W-1:0]   rapid_total;
        logic [ACC_W-1:0]   feed_total;
        logic [ACC_W-1:0]   plunge_total;
        logic [TALLY_W-1:0] segments_seen;
        logic [ACC_W-1:0]   minutes_total;
        logic [TALLY_W-1:0] retracts_seen;
        logic               rate_fault;
    } t_totals;

    logic [RATE_W-1:0] traverse_rate;
    t_totals           running_totals;
    t_totals           totals_due[$];
    int                fails     = 0;
    int                due_count = 0;

    assign o_fails       = fails;
    assign o_results_due = due_count;

    // Floor of the Euclidean length, found bit by bit from the top.
    function automatic logic [LEN_W-1:0] segment_length(input logic [S_DATA_W-1:0] d);
        logic [SQSUM_W-1:0] sq_sum;
        logic [MAG_W-1:0]   mag;
        logic [LEN_W-1:0]   root;
        logic [LEN_W-1:0]   trial;
        logic [SQSUM_W-1:0] trial_sq;
        longint             delta;
        sq_sum = '0;
        root   = '0;
        for (int axis = 0; axis < 3; axis++) begin
            delta = longint'($signed(d[3*COORD_W + COORD_W*axis +: COORD_W]))
                  - longint'($signed(d[COORD_W*axis +: COORD_W]));
            mag = (delta < 0) ? MAG_W'(-delta) : MAG_W'(delta);
            sq_sum = sq_sum + SQSUM_W'(mag) * SQSUM_W'(mag);
        end
        for (int b = LEN_W - 1; b >= 0; b--) begin
            trial    = root | (LEN_W'(1) << b);
            trial_sq = SQSUM_W'(trial) * SQSUM_W'(trial);
            if (trial_sq <= sq_sum)
                root = trial;
        end
        return root;
    endfunction

    function automatic logic [ACC_W-1:0] add_saturating(input logic [ACC_W-1:0] acc,
                                                        input logic [63:0] amount);
        logic [64:0] sum;
        sum = 65'(acc) + 65'(amount);
        return (sum > 65'(ACC_MAX)) ? ACC_MAX : sum[ACC_W-1:0];
    endfunction

    function automatic logic [TALLY_W-1:0] bump_tally(input logic [TALLY_W-1:0] tally);
        return (tally == TALLY_MAX) ? tally : tally + 1'b1;
    endfunction

    task automatic take_request(input logic [S_USER_W-1:0] user,
                                input logic [S_DATA_W-1:0] data);
        logic [1:0]       kind;
        logic [LEN_W-1:0] len;
        logic [RATE_W-1:0] rate;
        logic [COORD_W-1:0] start_z;
        logic [COORD_W-1:0] end_z;
        if (user[0] == ACT_FINISH) begin
            totals_due.push_back(running_totals);
            running_totals = '0;
        end else begin
            kind    = user[2:1];
            len     = segment_length(data);
            start_z = data[2*COORD_W +: COORD_W];
            end_z   = data[5*COORD_W +: COORD_W];
            if (kind == KIND_RAPID) begin
                running_totals.rapid_total = add_saturating(running_totals.rapid_total, 64'(len));
                rate = traverse_rate;
                if ($signed(end_z) > $signed(start_z))
                    running_totals.retracts_seen = bump_tally(running_totals.retracts_seen);
            end else begin
                // Any kind other than rapid and feed counts as a plunge.
                if (kind == KIND_FEED)
                    running_totals.feed_total =
                        add_saturating(running_totals.feed_total, 64'(len));
                else
                    running_totals.plunge_total =
                        add_saturating(running_totals.plunge_total, 64'(len));
                rate = data[6*COORD_W +: RATE_W];
            end
            if (rate == '0)
                running_totals.rate_fault = 1'b1;
            else
                running_totals.minutes_total = add_saturating(running_totals.minutes_total,
                    (64'(len) << FRAC_W) / 64'(rate));
            running_totals.segments_seen = bump_tally(running_totals.segments_seen);
        end
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            if (fails < REPORT_LIMIT)
                $display("%0t checker: %s expected %0h got %0h", $realtime, name, want, got);
            fails++;
        end
    endtask

    task automatic check_result(input logic [M_DATA_W-1:0] data);
        t_totals want;
        if (totals_due.size() == 0) begin
            if (fails < REPORT_LIMIT)
                $display("%0t checker: result %0h arrived with none expected", $realtime, data);
            fails++;
        end else begin
            want = totals_due.pop_front();
            compare_field("rapid_total",   64'(want.rapid_total),   64'(data[0 +: ACC_W]));
            compare_field("feed_total",    64'(want.feed_total),    64'(data[48 +: ACC_W]));
            compare_field("plunge_total",  64'(want.plunge_total),  64'(data[96 +: ACC_W]));
            compare_field("segments_seen", 64'(want.segments_seen), 64'(data[144 +: TALLY_W]));
            compare_field("minutes_total", 64'(want.minutes_total), 64'(data[176 +: ACC_W]));
            compare_field("retracts_seen", 64'(want.retracts_seen), 64'(data[224 +: TALLY_W]));
            compare_field("rate_fault",    64'(want.rate_fault),    64'(data[256]));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            traverse_rate  = TRAVERSE_RATE_RESET;
            running_totals = '0;
            totals_due.delete();
        end else begin
            if (i_cfg_wr_en)
                traverse_rate = i_cfg_wr_data;
            if (i_s_tvalid && i_s_tready)
                take_request(i_s_tuser, i_s_tdata);
            if (i_m_tvalid && i_m_tready)
                check_result(i_m_tdata);
        end
        due_count = totals_due.size();
    end

endmodule
`default_nettype wire

FILE: bench/testbench.sv
// Top of the bench: drives requests into the toolpath statistics block and gives the verdict.
`timescale 1ns / 1ps
`default_nettype none
module testbench
    import tlts_pkg::*;
();

    // The run is far shorter than this; reaching it means the block has hung.
    localparam int CYCLE_LIMIT      = 1_000_000;
    // A segment keeps the block busy after it is taken; this margin covers any work still
    // in flight once the last result has been seen.
    localparam int SETTLE_CYCLES    = 200;
    localparam int LONG_HOLD_CYCLES = 2000;
    localparam int RANDOM_PHASES    = 8;
    localparam int PHASE_REQUESTS   = 100;

    // A kind outside the three named ones; the block treats it as a plunge.
    localparam logic [1:0]         KIND_OTHER = 2'd3;
    localparam logic [COORD_W-1:0] COORD_MIN  = 32'h8000_0000;
    localparam logic [COORD_W-1:0] COORD_MAX  = 32'h7fff_ffff;
    localparam logic [COORD_W-1:0] ONE_MM     = 32'h0001_0000;
    localparam logic [RATE_W-1:0]  RATE_MAX   = '1;
    localparam logic [RATE_W-1:0]  RATE_ZERO  = '0;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [RATE_W-1:0]   cfg_wr_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [S_USER_W-1:0] s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    int fails;
    int results_due;
    int cycle_count      = 0;

    // Idling switches, and the handshake between the stimulus and the receiver that asks
    // for a long hold-off on the master side.
    bit sender_idles     = 1'b1;
    bit receiver_idles   = 1'b1;
    int long_holds_asked = 0;
    int long_holds_done  = 0;

    // Where the tool stands, so that most random segments continue from the last one.
    logic [COORD_W-1:0] tool_x = '0;
    logic [COORD_W-1:0] tool_y = '0;
    logic [COORD_W-1:0] tool_z = '0;

    toolpath_length_time_statistics i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_s_tvalid    (s_tvalid),
        .o_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .o_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .o_m_tdata     (m_tdata)
    );

    toolpath_stats_checker stats_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .o_fails       (fails),
        .o_results_due (results_due)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Master side. Normally it takes results at once or after a short random stall; when a
    // long hold-off is asked for it stays low for a long stretch, counted here, so that a
    // finished result backs up and later finish requests are held off at the input.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge clk);
            if (long_holds_done < long_holds_asked) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_holds_done++;
            end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
                // The wait at the top of the loop also counts toward the idle stretch.
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 11)) @(posedge clk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offers one request, after an optional idle burst, and returns at the edge where it is
    // taken. The valid stays high so that back-to-back requests need no extra assignment.
    task automatic send_request(input logic act, input logic [1:0] kind,
                                input logic [S_DATA_W-1:0] payload);
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {kind, act};
        s_tdata  <= payload;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_segment(input logic [1:0] kind,
                                input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                                input logic [COORD_W-1:0] sz, input logic [COORD_W-1:0] ex,
                                input logic [COORD_W-1:0] ey, input logic [COORD_W-1:0] ez,
                                input logic [RATE_W-1:0] rate);
        tool_x = ex;
        tool_y = ey;
        tool_z = ez;
        send_request(ACT_SEGMENT, kind, {rate, ez, ey, ex, sz, sy, sx});
    endtask

    // A finish request carries random rubbish in every field it does not use.
    task automatic send_finish();
        send_request(ACT_FINISH, 2'($urandom_range(0, 3)),
                     {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                      $urandom(), $urandom()});
    endtask

    // Mostly coordinates within a metre or so of the origin, with the extremes and fully
    // random words mixed in.
    function automatic logic [COORD_W-1:0] random_coord();
        case ($urandom_range(0, 7)) inside
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            [2:3]:   return $urandom();
            default: return 32'($urandom_range(0, 1000 * 65536)) - 32'(500 * 65536);
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] nudge(input logic [COORD_W-1:0] from);
        return from + 32'($urandom_range(0, 100 * 65536)) - 32'(50 * 65536);
    endfunction

    function automatic logic [RATE_W-1:0] random_rate();
        case ($urandom_range(0, 15)) inside
            0:       return RATE_ZERO;
            1:       return 32'd1;
            2:       return RATE_MAX;
            [3:4]:   return $urandom();
            default: return 32'($urandom_range(65536, 20000 * 65536));
        endcase
    endfunction

    // Well-formed toolpath most of the time: continue from the tool position by a short
    // move, plunges going along z only; now and then jump anywhere.
    task automatic send_random_segment();
        logic [1:0]         kind;
        logic [COORD_W-1:0] sx, sy, sz, ex, ey, ez;
        case ($urandom_range(0, 9)) inside
            [0:2]:   kind = KIND_RAPID;
            [3:6]:   kind = KIND_FEED;
            [7:8]:   kind = KIND_PLUNGE;
            default: kind = KIND_OTHER;
        endcase
        if ($urandom_range(0, 19) < 17) begin
            sx = tool_x;
            sy = tool_y;
            sz = tool_z;
        end else begin
            sx = random_coord();
            sy = random_coord();
            sz = random_coord();
        end
        if ($urandom_range(0, 9) < 7) begin
            ex = (kind == KIND_PLUNGE) ? sx : nudge(sx);
            ey = (kind == KIND_PLUNGE) ? sy : nudge(sy);
            ez = nudge(sz);
        end else begin
            ex = random_coord();
            ey = random_coord();
            ez = random_coord();
        end
        send_segment(kind, sx, sy, sz, ex, ey, ez, random_rate());
    endtask

    // Stops offering requests and waits until every expected result is in, then lets any
    // segment still being worked on run out before the caller touches the register.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_traverse_rate(input logic [RATE_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int finish_odds;
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, with the rapid rate left at its reset value first. A rapid of zero
        // length whose own rate field is zero must not raise the fault flag.
        send_segment(KIND_RAPID, '0, '0, '0, '0, '0, '0, RATE_ZERO);
        // Rapids across the whole z range, rising (a retract) and falling.
        send_segment(KIND_RAPID, '0, '0, COORD_MIN, '0, '0, COORD_MAX, RATE_MAX);
        send_segment(KIND_RAPID, COORD_MIN, '0, COORD_MAX, COORD_MAX, '0, COORD_MIN, 32'd1);
        // Longest possible moves, at the fastest and the slowest non-zero feed.
        send_segment(KIND_FEED, COORD_MIN, COORD_MIN, COORD_MIN,
                     COORD_MAX, COORD_MAX, COORD_MAX, RATE_MAX);
        send_segment(KIND_FEED, COORD_MAX, COORD_MAX, COORD_MAX,
                     COORD_MIN, COORD_MIN, COORD_MIN, 32'd1);
        // A plunge with no rate adds length but no time and flags the fault.
        send_segment(KIND_PLUNGE, '0, '0, 10 * ONE_MM, '0, '0, -32'(5 * ONE_MM), RATE_ZERO);
        send_segment(KIND_OTHER, ONE_MM, ONE_MM, '0, 4 * ONE_MM, 5 * ONE_MM, '0,
                     1000 * ONE_MM);
        send_segment(KIND_FEED, '0, '0, '0, 10 * ONE_MM, '0, '0, 1000 * ONE_MM);
        send_finish();
        // A finish straight after a finish reports empty totals.
        send_finish();
        send_segment(KIND_FEED, ONE_MM, '0, '0, ONE_MM, ONE_MM, '0, RATE_ZERO);
        send_finish();
        drain_results();

        // Slowest rapid rate: every rapid costs a great deal of time.
        write_traverse_rate(32'd1);
        send_segment(KIND_RAPID, COORD_MIN, COORD_MIN, '0, COORD_MAX, COORD_MAX, ONE_MM,
                     RATE_ZERO);
        send_segment(KIND_RAPID, '0, '0, '0, ONE_MM, '0, '0, 1000 * ONE_MM);
        send_finish();
        drain_results();

        // A zero rapid rate makes rapids count as a rate fault while still adding length.
        write_traverse_rate(RATE_ZERO);
        send_segment(KIND_RAPID, '0, '0, '0, 3 * ONE_MM, 4 * ONE_MM, ONE_MM, 1000 * ONE_MM);
        send_finish();
        drain_results();

        write_traverse_rate(RATE_MAX);
        send_segment(KIND_RAPID, COORD_MAX, COORD_MAX, COORD_MAX,
                     COORD_MIN, COORD_MIN, COORD_MIN, RATE_MAX);
        send_finish();

        // Random part. Each phase starts from an idle block with a fresh rapid rate. The
        // third phase asks for a long hold-off on the master side and finishes often, so
        // that results pile up; the sixth runs without idling and the last one too.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_results();
            case (phase)
                0:       write_traverse_rate(32'd1);
                1:       write_traverse_rate(RATE_MAX);
                3:       write_traverse_rate($urandom());
                4:       write_traverse_rate(32'($urandom_range(65536, 20000 * 65536)));
                6:       write_traverse_rate(RATE_MAX);
                default: write_traverse_rate(TRAVERSE_RATE_RESET);
            endcase
            sender_idles   = (phase != 5) && (phase != RANDOM_PHASES - 1);
            receiver_idles = sender_idles;
            finish_odds    = (phase == 2) ? 3 : 11;
            if (phase == 2)
                long_holds_asked++;
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                if ($urandom_range(0, finish_odds) == 0)
                    send_finish();
                else
                    send_random_segment();
            end
            send_finish();
        end

        drain_results();
        if (fails == 0 && results_due == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire

FILE: filelist.f
src/tlts_pkg.sv
src/tlts_sqsum.sv
src/tlts_sqrt.sv
src/tlts_div.sv
src/toolpath_length_time_statistics.sv
bench/toolpath_stats_checker.sv
bench/testbench.sv
